### rtl/tcc_pkg.sv
// Shared types, codes and the 256-entry color palette table for the terminal cell
// color resolver. The table is built once at elaboration. No dependencies.
`timescale 1ns / 1ps

package tcc_pkg;

	// Default width of the row and column compare.
	localparam int COORD_BITS_DEFAULT = 8;

	localparam int RGB_BITS     = 24;
	localparam int INDEX_BITS   = 8;
	localparam int PALETTE_SIZE = 256;

	typedef logic [RGB_BITS-1:0] rgb_t;
	typedef logic [1:0] mode_t;
	typedef logic [1:0] span_t;
	typedef logic [2:0] cfg_index_t;
	typedef rgb_t palette_t [PALETTE_SIZE];

	// Color source codes.
	localparam mode_t MODE_DEFAULT = 2'd0;
	localparam mode_t MODE_PALETTE = 2'd1;

	// Cell span codes.
	localparam span_t SPAN_TRAILING = 2'd0;

	// Configuration register indexes.
	localparam cfg_index_t REG_DEFAULT_FG   = 3'd0;
	localparam cfg_index_t REG_DEFAULT_BG   = 3'd1;
	localparam cfg_index_t REG_CURSOR_ROW   = 3'd2;
	localparam cfg_index_t REG_CURSOR_COL   = 3'd3;
	localparam cfg_index_t REG_CURSOR_EN    = 3'd4;
	localparam cfg_index_t REG_SEL_START    = 3'd5;
	localparam cfg_index_t REG_SEL_END      = 3'd6;
	localparam cfg_index_t REG_SEL_ACTIVE   = 3'd7;

	// Reset values of the default colors.
	localparam rgb_t DEFAULT_FG_RESET = 24'hCCCCCC;
	localparam rgb_t DEFAULT_BG_RESET = 24'h0C0C0C;
	localparam rgb_t RGB_WHITE        = 24'hFFFFFF;

	// Geometry of the palette: named colors, color cube, gray ramp.
	localparam int NAMED_COUNT = 16;
	localparam int CUBE_SIDE   = 6;
	localparam int CUBE_STEP   = 40;
	localparam int CUBE_BASE   = 55;
	localparam int GRAY_FIRST  = 232;
	localparam int GRAY_STEP   = 10;
	localparam int GRAY_BASE   = 8;

	localparam rgb_t NAMED_COLORS [NAMED_COUNT] = '{
		24'h0C0C0C, 24'hC50F1F, 24'h13A10E, 24'hC19C00,
		24'h0037DA, 24'h881798, 24'h3A96DD, 24'hCCCCCC,
		24'h767676, 24'hE74856, 24'h16C60C, 24'hF9F1A5,
		24'h3B78FF, 24'hB4009E, 24'h61D6D6, 24'hF2F2F2
	};

	// Channel level of one cube step: zero stays dark, others ramp up.
	function automatic logic [7:0] cube_level(input int step);
		if (step == 0) begin
			return 8'd0;
		end
		return 8'(step * CUBE_STEP + CUBE_BASE);
	endfunction

	// Build the full palette with running counters, evaluated at elaboration.
	function automatic palette_t build_palette();
		palette_t p;
		int idx;
		int r;
		int g;
		int b;
		logic [7:0] v;
		for (idx = 0; idx < NAMED_COUNT; idx++) begin
			p[idx] = NAMED_COLORS[idx];
		end
		idx = NAMED_COUNT;
		for (r = 0; r < CUBE_SIDE; r++) begin
			for (g = 0; g < CUBE_SIDE; g++) begin
				for (b = 0; b < CUBE_SIDE; b++) begin
					p[idx] = {cube_level(r), cube_level(g), cube_level(b)};
					idx++;
				end
			end
		end
		for (idx = GRAY_FIRST; idx < PALETTE_SIZE; idx++) begin
			v = 8'((idx - GRAY_FIRST) * GRAY_STEP + GRAY_BASE);
			p[idx] = {v, v, v};
		end
		return p;
	endfunction

	localparam palette_t PALETTE = build_palette();

endpackage

### rtl/tcc_color_side.sv
// One side (foreground or background) of the cell color selection.
// Depends on tcc_pkg for the palette table and the source codes.
`timescale 1ns / 1ps

module tcc_color_side (
	input  tcc_pkg::mode_t                    mode,
	input  logic [tcc_pkg::INDEX_BITS-1:0]    index,
	input  tcc_pkg::rgb_t                     direct,
	input  tcc_pkg::rgb_t                     dflt,
	input  logic                              brighten,
	output tcc_pkg::rgb_t                     color
);

	logic [tcc_pkg::INDEX_BITS-1:0] lookup_index;

	// Bold lifts the eight low palette entries to their bright versions.
	always_comb begin
		lookup_index = index;
		if (brighten && index[tcc_pkg::INDEX_BITS-1:3] == '0) begin
			lookup_index[3] = 1'b1;
		end
	end

	// Source select; the upper mode bit means direct RGB.
	always_comb begin
		priority if (mode == tcc_pkg::MODE_DEFAULT) begin
			color = dflt;
		end else if (mode[1]) begin
			color = direct;
		end else begin
			color = tcc_pkg::PALETTE[lookup_index];
		end
	end

endmodule

### rtl/terminal_cell_color_resolver.sv
// Top level of the terminal cell color resolver: input register, color and
// position logic, result register. Depends on tcc_pkg and tcc_color_side.
`timescale 1ns / 1ps

// The block takes one cell in every clock cycle: busy stays low, so a transfer
// happens whenever start is high. Each cell yields one result. The result is shown
// on the result ports with done high for one cycle, after the cell has passed the
// input register and then the result register; the receiver cannot stall it.
// Between those two registers lie one palette lookup and the position compares.
// Configuration writes take effect at once and belong in idle time.
module terminal_cell_color_resolver #(
	parameter int COORD_BITS = tcc_pkg::COORD_BITS_DEFAULT
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// Cell input.
	input  logic                           start,
	output logic                           busy,
	input  logic [7:0]                     row,
	input  logic [7:0]                     column,
	input  logic [tcc_pkg::INDEX_BITS-1:0] fg_index,
	input  logic [tcc_pkg::INDEX_BITS-1:0] bg_index,
	input  tcc_pkg::rgb_t                  fg_direct,
	input  tcc_pkg::rgb_t                  bg_direct,
	input  tcc_pkg::mode_t                 fg_mode,
	input  tcc_pkg::mode_t                 bg_mode,
	input  logic                           bold,
	input  logic                           inverse,
	input  logic                           underline,
	input  tcc_pkg::span_t                 cell_span,
	// Configuration write port.
	input  logic                           cfg_we,
	input  tcc_pkg::cfg_index_t            cfg_index,
	input  logic [23:0]                    cfg_data,
	// Result.
	output logic                           done,
	output tcc_pkg::rgb_t                  fg_color,
	output tcc_pkg::rgb_t                  bg_color,
	output logic                           fill_background,
	output logic                           draw_underline,
	output logic                           in_selection,
	output logic                           at_cursor,
	output logic                           skip_cell
);

	localparam int KEY_BITS = 2 * COORD_BITS;

	// Configuration registers.
	tcc_pkg::rgb_t default_fg_q;
	tcc_pkg::rgb_t default_bg_q;
	logic [7:0]    cursor_row_q;
	logic [7:0]    cursor_col_q;
	logic          cursor_en_q;
	logic [15:0]   sel_start_q;
	logic [15:0]   sel_end_q;
	logic          sel_active_q;

	// Input stage.
	logic                           valid_s1;
	logic [7:0]                     row_s1;
	logic [7:0]                     column_s1;
	logic [tcc_pkg::INDEX_BITS-1:0] fg_index_s1;
	logic [tcc_pkg::INDEX_BITS-1:0] bg_index_s1;
	tcc_pkg::rgb_t                  fg_direct_s1;
	tcc_pkg::rgb_t                  bg_direct_s1;
	tcc_pkg::mode_t                 fg_mode_s1;
	tcc_pkg::mode_t                 bg_mode_s1;
	logic                           bold_s1;
	logic                           inverse_s1;
	logic                           underline_s1;
	tcc_pkg::span_t                 span_s1;

	// Result stage.
	logic          done_s2;
	tcc_pkg::rgb_t fg_s2;
	tcc_pkg::rgb_t bg_s2;
	logic          fill_s2;
	logic          underline_s2;
	logic          selected_s2;
	logic          cursor_s2;
	logic          skip_s2;

	// Combinational results.
	tcc_pkg::rgb_t         fg_side;
	tcc_pkg::rgb_t         bg_side;
	logic [COORD_BITS-1:0] row_c;
	logic [COORD_BITS-1:0] col_c;
	logic [KEY_BITS-1:0]   cell_key;
	logic [KEY_BITS-1:0]   sel_a;
	logic [KEY_BITS-1:0]   sel_b;
	logic                  cursor_hit;
	logic                  selected;
	logic                  swap;
	logic                  skip;
	tcc_pkg::rgb_t         fg_final;
	tcc_pkg::rgb_t         bg_final;
	logic                  fill;

	logic transfer;

	assign busy     = 1'b0;
	assign transfer = start && !busy;

	// Configuration register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_fg_q <= tcc_pkg::DEFAULT_FG_RESET;
			default_bg_q <= tcc_pkg::DEFAULT_BG_RESET;
			cursor_row_q <= '0;
			cursor_col_q <= '0;
			cursor_en_q  <= 1'b0;
			sel_start_q  <= '0;
			sel_end_q    <= '0;
			sel_active_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tcc_pkg::REG_DEFAULT_FG: default_fg_q <= cfg_data;
				tcc_pkg::REG_DEFAULT_BG: default_bg_q <= cfg_data;
				tcc_pkg::REG_CURSOR_ROW: cursor_row_q <= cfg_data[7:0];
				tcc_pkg::REG_CURSOR_COL: cursor_col_q <= cfg_data[7:0];
				tcc_pkg::REG_CURSOR_EN:  cursor_en_q  <= cfg_data[0];
				tcc_pkg::REG_SEL_START:  sel_start_q  <= cfg_data[15:0];
				tcc_pkg::REG_SEL_END:    sel_end_q    <= cfg_data[15:0];
				tcc_pkg::REG_SEL_ACTIVE: sel_active_q <= cfg_data[0];
			endcase
		end
	end

	// Input register: a cell is captured on every transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= transfer;
		end
	end

	always_ff @(posedge clk) begin
		if (transfer) begin
			row_s1       <= row;
			column_s1    <= column;
			fg_index_s1  <= fg_index;
			bg_index_s1  <= bg_index;
			fg_direct_s1 <= fg_direct;
			bg_direct_s1 <= bg_direct;
			fg_mode_s1   <= fg_mode;
			bg_mode_s1   <= bg_mode;
			bold_s1      <= bold;
			inverse_s1   <= inverse;
			underline_s1 <= underline;
			span_s1      <= cell_span;
		end
	end

	// Color source selection for each side.
	tcc_color_side u_fg_side (
		.mode     (fg_mode_s1),
		.index    (fg_index_s1),
		.direct   (fg_direct_s1),
		.dflt     (default_fg_q),
		.brighten (bold_s1),
		.color    (fg_side)
	);

	tcc_color_side u_bg_side (
		.mode     (bg_mode_s1),
		.index    (bg_index_s1),
		.direct   (bg_direct_s1),
		.dflt     (default_bg_q),
		.brighten (1'b0),
		.color    (bg_side)
	);

	// Position compares on the low coordinate bits.
	assign row_c    = COORD_BITS'(row_s1);
	assign col_c    = COORD_BITS'(column_s1);
	assign cell_key = {row_c, col_c};
	assign sel_a    = {COORD_BITS'(sel_start_q >> COORD_BITS), COORD_BITS'(sel_start_q)};
	assign sel_b    = {COORD_BITS'(sel_end_q >> COORD_BITS), COORD_BITS'(sel_end_q)};

	assign cursor_hit = cursor_en_q
		&& row_c == COORD_BITS'(cursor_row_q)
		&& col_c == COORD_BITS'(cursor_col_q);

	// Inclusive range test in either order of the two selection points.
	assign selected = sel_active_q
		&& ((cell_key >= sel_a && cell_key <= sel_b)
		|| (cell_key >= sel_b && cell_key <= sel_a));

	// Inverse video and the cursor each swap the colors; selection forces the foreground white.
	assign swap     = inverse_s1 ^ cursor_hit;
	assign fg_final = selected ? tcc_pkg::RGB_WHITE : (swap ? bg_side : fg_side);
	assign bg_final = swap ? fg_side : bg_side;
	assign fill     = !selected
		&& (bg_mode_s1 != tcc_pkg::MODE_DEFAULT || inverse_s1 || cursor_hit);
	assign skip     = span_s1 == tcc_pkg::SPAN_TRAILING;

	// Result register; the trailing half of a wide character carries only the skip flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s2 <= 1'b0;
		end else begin
			done_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			skip_s2 <= skip;
			if (skip) begin
				fg_s2        <= '0;
				bg_s2        <= '0;
				fill_s2      <= 1'b0;
				underline_s2 <= 1'b0;
				selected_s2  <= 1'b0;
				cursor_s2    <= 1'b0;
			end else begin
				fg_s2        <= fg_final;
				bg_s2        <= bg_final;
				fill_s2      <= fill;
				underline_s2 <= underline_s1;
				selected_s2  <= selected;
				cursor_s2    <= cursor_hit;
			end
		end
	end

	assign done            = done_s2;
	assign fg_color        = fg_s2;
	assign bg_color        = bg_s2;
	assign fill_background = fill_s2;
	assign draw_underline  = underline_s2;
	assign in_selection    = selected_s2;
	assign at_cursor       = cursor_s2;
	assign skip_cell       = skip_s2;

`ifndef NO_ASSERTIONS
	// Every result comes from a matching cell transfer, through the input and result registers.
	a_done_from_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(transfer, 2))
		else $error("result strobe without a matching cell transfer");

	// A captured cell always yields a result in the next cycle.
	a_stage_advances: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |=> done)
		else $error("captured cell produced no result");

	// A skipped cell carries no color and no drawing flags.
	a_skip_clear: assert property (@(posedge clk) disable iff (!arst_n)
		done && skip_cell |-> fg_color == '0 && bg_color == '0 && !fill_background
			&& !draw_underline && !in_selection && !at_cursor)
		else $error("skipped cell carries drawing data");

	// Selected cells are drawn white on an unpainted background.
	a_selection_white: assert property (@(posedge clk) disable iff (!arst_n)
		done && in_selection |-> fg_color == tcc_pkg::RGB_WHITE && !fill_background)
		else $error("selected cell not forced to white without fill");

	// The cursor always forces a background fill unless the cell is selected.
	a_cursor_fill: assert property (@(posedge clk) disable iff (!arst_n)
		done && at_cursor && !in_selection |-> fill_background)
		else $error("cursor cell without background fill");
`endif

endmodule
